>>> src/gpoc_pkg.sv
`default_nettype none
package gpoc_pkg;

   localparam int PIN_COUNT = 32;
   localparam int MAX_PINS  = 32;
   localparam int IDX_W     = 5;
   localparam int PIN_W     = 6;
   localparam int ID_W      = 22;
   localparam int BANK_W    = 32;
   localparam int CNT_W     = 16;

   localparam logic [BANK_W-1:0] RESERVED_RESET = 32'h0439_3063;
   localparam logic [CNT_W-1:0]  CNT_MAX        = {CNT_W{1'b1}};

   typedef enum logic [2:0] {
      CMD_REQUEST = 3'd0,
      CMD_FREE    = 3'd1,
      CMD_MODE    = 3'd2,
      CMD_READ    = 3'd3,
      CMD_WRITE   = 3'd4,
      CMD_TOGGLE  = 3'd5,
      CMD_OPEN    = 3'd6,
      CMD_CLOSE   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IN      = 2'd0,
      MODE_OUT     = 2'd1,
      MODE_INTR    = 2'd2,
      MODE_INVALID = 2'd3
   } mode_type;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FAULT   = 3'd1;
   localparam logic [2:0] ST_BUSY    = 3'd2;
   localparam logic [2:0] ST_DENIED  = 3'd3;
   localparam logic [2:0] ST_BADMODE = 3'd4;

   typedef struct packed {
      logic [PIN_W-1:0] pin;
      logic [ID_W-1:0]  id;
      logic [2:0]       cmd;
      logic [1:0]       mode;
      logic             wval;
      logic             samp;
   } cmd_beat_type;

   typedef struct packed {
      logic [BANK_W-1:0] mask;
      logic [BANK_W-1:0] dir;
      logic [BANK_W-1:0] lvl;
      logic [BANK_W-1:0] irq;
      logic [CNT_W-1:0]  count;
   } bank_state_type;

   typedef struct packed {
      logic [2:0]        status;
      logic              rval;
      logic [BANK_W-1:0] dir;
      logic [BANK_W-1:0] lvl;
      logic [BANK_W-1:0] irq;
      logic [CNT_W-1:0]  count;
      logic              own_we;
      logic              vld_set;
      logic              vld_clr;
      logic              close_all;
   } exec_result_type;

endpackage
`default_nettype wire

>>> src/gpio_pin_ownership_controller.sv
`default_nettype none
// GPIO pin ownership controller, 32 pins.
// Command channel (req_*): one beat per command: cmd, pin, requester id, mode,
// write level and the sampled pin level. Result channel (rsp_*): one beat per
// command: status, read value and the bank's level, direction and irq-enable
// vectors after the command. csr_wr_en/csr_wr_data load the reserved pin mask;
// write it only while no command is in flight.
// Owners live in a 32 x 22 synchronous RAM with a registered read, plus one valid
// flop per pin so that the last close frees all unreserved pins at once.
// Flow: a command is read from the owner RAM at the edge that accepts it, then
// executed and written back when it commits from ST_EXEC; its result is valid
// from then on. The block takes no new command until the last one commits:
// req_stall is high while a command waits in ST_EXEC.
// A result waiting under rsp_stall does not block acceptance of the next
// command; that command holds in its execute step until the result slot frees.
// Reset: all pins free, all outputs, levels low, irqs off, user count zero,
// reserved mask back to its default; rsp_valid drops and req_stall is low.
module gpio_pin_ownership_controller (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [2:0]                    req_cmd,
   input  wire logic [gpoc_pkg::PIN_W-1:0]    req_pin,
   input  wire logic [gpoc_pkg::ID_W-1:0]     req_requester_id,
   input  wire logic [1:0]                    req_mode_value,
   input  wire logic                          req_write_value,
   input  wire logic                          req_sampled_level,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2:0]                         rsp_status,
   output logic                               rsp_read_value,
   output logic [gpoc_pkg::BANK_W-1:0]        rsp_output_levels,
   output logic [gpoc_pkg::BANK_W-1:0]        rsp_direction_bits,
   output logic [gpoc_pkg::BANK_W-1:0]        rsp_irq_enables,
   input  wire logic                          csr_wr_en,
   input  wire logic [gpoc_pkg::BANK_W-1:0]   csr_wr_data
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                        state_ff;
   logic                             rsp_valid_ff;
   gpoc_pkg::cmd_beat_type           beat_ff;
   gpoc_pkg::cmd_beat_type           beat_in;
   gpoc_pkg::bank_state_type         bank_ff;
   logic [gpoc_pkg::MAX_PINS-1:0]    owner_vld_ff;
   logic [gpoc_pkg::MAX_PINS-1:0]    owner_vld_in;
   logic [2:0]                       status_ff;
   logic                             rval_ff;

   logic                             accept;
   logic                             commit;
   logic [gpoc_pkg::IDX_W-1:0]       idx;
   logic [gpoc_pkg::ID_W-1:0]        ram_rd_data;
   logic [gpoc_pkg::ID_W-1:0]        owner;
   gpoc_pkg::exec_result_type        res;

   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);
   assign idx       = beat_ff.pin[gpoc_pkg::IDX_W-1:0];
   assign owner     = owner_vld_ff[idx] ? ram_rd_data : '0;

   assign beat_in.pin  = req_pin;
   assign beat_in.id   = req_requester_id;
   assign beat_in.cmd  = req_cmd;
   assign beat_in.mode = req_mode_value;
   assign beat_in.wval = req_write_value;
   assign beat_in.samp = req_sampled_level;

   gpoc_ram #(
      .WIDTH (gpoc_pkg::ID_W),
      .DEPTH (gpoc_pkg::MAX_PINS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (commit && res.own_we),
      .wr_addr (idx),
      .wr_data (beat_ff.id),
      .rd_en   (accept),
      .rd_addr (req_pin[gpoc_pkg::IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   gpoc_exec u_exec (
      .beat  (beat_ff),
      .owner (owner),
      .bank  (bank_ff),
      .res   (res)
   );

   always_comb begin
      owner_vld_in = owner_vld_ff;
      if (res.vld_set) begin
         owner_vld_in[idx] = 1'b1;
      end
      if (res.vld_clr) begin
         owner_vld_in[idx] = 1'b0;
      end
      if (res.close_all) begin
         owner_vld_in = owner_vld_ff & bank_ff.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         owner_vld_ff  <= '0;
         bank_ff.mask  <= gpoc_pkg::RESERVED_RESET;
         bank_ff.dir   <= '1;
         bank_ff.lvl   <= '0;
         bank_ff.irq   <= '0;
         bank_ff.count <= '0;
      end else begin
         if (csr_wr_en) begin
            bank_ff.mask <= csr_wr_data;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  beat_ff  <= beat_in;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (commit) begin
                  owner_vld_ff  <= owner_vld_in;
                  bank_ff.dir   <= res.dir;
                  bank_ff.lvl   <= res.lvl;
                  bank_ff.irq   <= res.irq;
                  bank_ff.count <= res.count;
                  status_ff     <= res.status;
                  rval_ff       <= res.rval;
                  state_ff      <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_read_value     = rval_ff;
   assign rsp_output_levels  = bank_ff.lvl;
   assign rsp_direction_bits = bank_ff.dir;
   assign rsp_irq_enables    = bank_ff.irq;

endmodule
`default_nettype wire

>>> src/gpoc_ram.sv
`default_nettype none
module gpoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> src/gpoc_exec.sv
`default_nettype none
module gpoc_exec (
   input  wire gpoc_pkg::cmd_beat_type    beat,
   input  wire logic [gpoc_pkg::ID_W-1:0] owner,
   input  wire gpoc_pkg::bank_state_type  bank,
   output gpoc_pkg::exec_result_type      res
);

   logic                          in_range;
   logic [gpoc_pkg::IDX_W-1:0]    idx;
   logic [gpoc_pkg::BANK_W-1:0]   bit_sel;
   logic                          usable;
   logic                          is_owner;

   assign in_range = beat.pin < gpoc_pkg::PIN_W'(gpoc_pkg::PIN_COUNT);
   assign idx      = beat.pin[gpoc_pkg::IDX_W-1:0];
   assign bit_sel  = in_range ? (gpoc_pkg::BANK_W'(1) << idx) : '0;
   assign usable   = in_range && !bank.mask[idx];
   assign is_owner = (beat.id != '0) && (owner == beat.id);

   always_comb begin
      res           = '0;
      res.status    = gpoc_pkg::ST_OK;
      res.dir       = bank.dir;
      res.lvl       = bank.lvl;
      res.irq       = bank.irq;
      res.count     = bank.count;
      unique case (gpoc_pkg::cmd_type'(beat.cmd))
         gpoc_pkg::CMD_REQUEST: begin
            if (!usable) begin
               res.status = gpoc_pkg::ST_FAULT;
            end else if (owner != '0) begin
               res.status = gpoc_pkg::ST_BUSY;
            end else begin
               res.own_we  = 1'b1;
               res.vld_set = 1'b1;
            end
         end
         gpoc_pkg::CMD_FREE: begin
            if (!usable) begin
               res.status = gpoc_pkg::ST_FAULT;
            end else if (!is_owner) begin
               res.status = gpoc_pkg::ST_DENIED;
            end else begin
               res.vld_clr = 1'b1;
            end
         end
         gpoc_pkg::CMD_MODE: begin
            if (!usable) begin
               res.status = gpoc_pkg::ST_FAULT;
            end else if (!is_owner) begin
               res.status = gpoc_pkg::ST_DENIED;
            end else begin
               unique case (gpoc_pkg::mode_type'(beat.mode))
                  gpoc_pkg::MODE_IN: begin
                     res.dir = bank.dir & ~bit_sel;
                  end
                  gpoc_pkg::MODE_OUT: begin
                     res.dir = bank.dir | bit_sel;
                     res.lvl = bank.lvl | bit_sel;
                  end
                  gpoc_pkg::MODE_INTR: begin
                     res.irq = bank.irq | bit_sel;
                  end
                  gpoc_pkg::MODE_INVALID: begin
                     res.status = gpoc_pkg::ST_BADMODE;
                  end
               endcase
            end
         end
         gpoc_pkg::CMD_READ: begin
            if (!in_range) begin
               res.status = gpoc_pkg::ST_FAULT;
            end else if (bank.dir[idx]) begin
               res.rval = bank.lvl[idx];
            end else begin
               res.rval = beat.samp;
            end
         end
         gpoc_pkg::CMD_WRITE, gpoc_pkg::CMD_TOGGLE: begin
            if (!usable) begin
               res.status = gpoc_pkg::ST_FAULT;
            end else if (!is_owner || !bank.dir[idx]) begin
               res.status = gpoc_pkg::ST_DENIED;
            end else if (beat.cmd == gpoc_pkg::CMD_WRITE) begin
               res.lvl = beat.wval ? (bank.lvl | bit_sel) : (bank.lvl & ~bit_sel);
            end else begin
               res.lvl  = bank.lvl ^ bit_sel;
               res.rval = ~bank.lvl[idx];
            end
         end
         gpoc_pkg::CMD_OPEN: begin
            if (bank.count != gpoc_pkg::CNT_MAX) begin
               res.count = bank.count + gpoc_pkg::CNT_W'(1);
            end
         end
         gpoc_pkg::CMD_CLOSE: begin
            if (bank.count != '0) begin
               res.count     = bank.count - gpoc_pkg::CNT_W'(1);
               res.close_all = (bank.count == gpoc_pkg::CNT_W'(1));
            end
         end
      endcase
   end

endmodule
`default_nettype wire

>>> src/gpoc_checker.sv
`default_nettype none
module gpoc_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [2:0]  rsp_status,
   input  wire logic        rsp_read_value
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("command channel not stalled during lookup");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value))
      else $error("stalled result beat changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == gpoc_pkg::ST_OK || rsp_status == gpoc_pkg::ST_FAULT
         || rsp_status == gpoc_pkg::ST_BUSY || rsp_status == gpoc_pkg::ST_DENIED
         || rsp_status == gpoc_pkg::ST_BADMODE)
      else $error("result status out of range");

   a_rval_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != gpoc_pkg::ST_OK |-> !rsp_read_value)
      else $error("read value set on failed command");

   a_rsp_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat without a command in flight");

endmodule

bind gpio_pin_ownership_controller gpoc_checker u_gpoc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_read_value (rsp_read_value)
);
`default_nettype wire

>>> tb/tb_gpio_pin_ownership_controller.sv
`timescale 1ns / 1ps
module tb_gpio_pin_ownership_controller;

   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      gpoc_pkg::cmd_type  cmd;
      logic [5:0]         pin;
      logic [21:0]        id;
      gpoc_pkg::mode_type mode;
      logic               wval;
      logic               samp;
   } gpio_cmd_type;

   typedef struct {
      logic [2:0]  status;
      logic        rval;
      logic [31:0] lvl;
      logic [31:0] dir;
      logic [31:0] irq;
   } gpio_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = '0;
   logic [5:0]  req_pin = '0;
   logic [21:0] req_requester_id = '0;
   logic [1:0]  req_mode_value = '0;
   logic        req_write_value = 1'b0;
   logic        req_sampled_level = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_read_value;
   logic [31:0] rsp_output_levels;
   logic [31:0] rsp_direction_bits;
   logic [31:0] rsp_irq_enables;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // predictor state
   logic [31:0] mdl_mask;
   logic [21:0] pin_owner [32];
   logic [31:0] mdl_dir;
   logic [31:0] mdl_lvl;
   logic [31:0] mdl_irq;
   logic [15:0] user_count;

   gpio_rsp_type pending_rsp [$];
   gpio_rsp_type rsp_want;
   int           fail_count = 0;
   int           quiet_cycles = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;

   gpio_pin_ownership_controller uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_pin            (req_pin),
      .req_requester_id   (req_requester_id),
      .req_mode_value     (req_mode_value),
      .req_write_value    (req_write_value),
      .req_sampled_level  (req_sampled_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value),
      .rsp_output_levels  (rsp_output_levels),
      .rsp_direction_bits (rsp_direction_bits),
      .rsp_irq_enables    (rsp_irq_enables),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic predict_gpio(input gpio_cmd_type c);
      gpio_rsp_type r;
      logic [31:0]  pin_bit;
      logic         in_range;
      logic         usable;
      logic         owned;
      r.status = gpoc_pkg::ST_OK;
      r.rval   = 1'b0;
      in_range = (c.pin < 6'(gpoc_pkg::PIN_COUNT));
      pin_bit  = in_range ? (32'h1 << c.pin[4:0]) : '0;
      usable   = in_range && !mdl_mask[c.pin[4:0]];
      owned    = in_range && (c.id != '0) && (pin_owner[c.pin[4:0]] == c.id);
      case (c.cmd)
         gpoc_pkg::CMD_REQUEST: begin
            if (!usable) r.status = gpoc_pkg::ST_FAULT;
            else if (pin_owner[c.pin[4:0]] != '0) r.status = gpoc_pkg::ST_BUSY;
            else pin_owner[c.pin[4:0]] = c.id;
         end
         gpoc_pkg::CMD_FREE: begin
            if (!usable) r.status = gpoc_pkg::ST_FAULT;
            else if (!owned) r.status = gpoc_pkg::ST_DENIED;
            else pin_owner[c.pin[4:0]] = '0;
         end
         gpoc_pkg::CMD_MODE: begin
            if (!usable) r.status = gpoc_pkg::ST_FAULT;
            else if (!owned) r.status = gpoc_pkg::ST_DENIED;
            else begin
               case (c.mode)
                  gpoc_pkg::MODE_IN:  mdl_dir &= ~pin_bit;
                  gpoc_pkg::MODE_OUT: begin
                     mdl_dir |= pin_bit;
                     mdl_lvl |= pin_bit;
                  end
                  gpoc_pkg::MODE_INTR: mdl_irq |= pin_bit;
                  default:             r.status = gpoc_pkg::ST_BADMODE;
               endcase
            end
         end
         gpoc_pkg::CMD_READ: begin
            if (!in_range) r.status = gpoc_pkg::ST_FAULT;
            else if ((mdl_dir & pin_bit) != '0) r.rval = ((mdl_lvl & pin_bit) != '0);
            else r.rval = c.samp;
         end
         gpoc_pkg::CMD_WRITE, gpoc_pkg::CMD_TOGGLE: begin
            if (!usable) r.status = gpoc_pkg::ST_FAULT;
            else if (!owned || (mdl_dir & pin_bit) == '0) r.status = gpoc_pkg::ST_DENIED;
            else if (c.cmd == gpoc_pkg::CMD_WRITE) begin
               if (c.wval) mdl_lvl |= pin_bit;
               else mdl_lvl &= ~pin_bit;
            end else begin
               mdl_lvl ^= pin_bit;
               r.rval = ((mdl_lvl & pin_bit) != '0);
            end
         end
         gpoc_pkg::CMD_OPEN: begin
            if (user_count != 16'hFFFF) user_count++;
         end
         default: begin
            if (user_count != '0) begin
               user_count--;
               if (user_count == '0) begin
                  for (int i = 0; i < gpoc_pkg::PIN_COUNT; i++)
                     if (!mdl_mask[i]) pin_owner[i] = '0;
               end
            end
         end
      endcase
      r.lvl = mdl_lvl;
      r.dir = mdl_dir;
      r.irq = mdl_irq;
      pending_rsp.push_back(r);
   endtask

   task automatic send_cmd(input gpoc_pkg::cmd_type c, input logic [5:0] p,
                           input logic [21:0] id, input gpoc_pkg::mode_type m,
                           input logic wv, input logic sl);
      int           gap;
      gpio_cmd_type beat;
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      beat = '{c, p, id, m, wv, sl};
      req_valid         <= 1'b1;
      req_cmd           <= c;
      req_pin           <= p;
      req_requester_id  <= id;
      req_mode_value    <= m;
      req_write_value   <= wv;
      req_sampled_level <= sl;
      do @(posedge clock); while (req_stall);
      predict_gpio(beat);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_reserved_mask(input logic [31:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mdl_mask = v;
   endtask

   task automatic set_idling(input int s, input int r);
      send_idle_pct = s;
      recv_idle_pct = r;
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result beat with nothing expected");
            fail_count++;
         end else begin
            rsp_want = pending_rsp.pop_front();
            check_field("status", 32'(rsp_want.status), 32'(rsp_status));
            check_field("read_value", 32'(rsp_want.rval), 32'(rsp_read_value));
            check_field("output_levels", rsp_want.lvl, rsp_output_levels);
            check_field("direction_bits", rsp_want.dir, rsp_direction_bits);
            check_field("irq_enables", rsp_want.irq, rsp_irq_enables);
         end
      end
      rsp_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_gpio_pin_ownership_controller NOT OK");
         $finish;
      end
   end

   // pin 2 is free under the default mask
   task automatic test_pin_ownership();
      send_cmd(gpoc_pkg::CMD_REQUEST, 6'd2, 22'h3FFFFF, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_REQUEST, 6'd2, 22'd1, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_MODE, 6'd2, 22'd1, gpoc_pkg::MODE_OUT, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_MODE, 6'd2, 22'h3FFFFF, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_READ, 6'd2, 22'd1, gpoc_pkg::MODE_IN, 1'b0, 1'b1);
      send_cmd(gpoc_pkg::CMD_WRITE, 6'd2, 22'h3FFFFF, gpoc_pkg::MODE_IN, 1'b1, 1'b0);
      send_cmd(gpoc_pkg::CMD_TOGGLE, 6'd2, 22'h3FFFFF, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_MODE, 6'd2, 22'h3FFFFF, gpoc_pkg::MODE_OUT, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_WRITE, 6'd2, 22'h3FFFFF, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_TOGGLE, 6'd2, 22'h3FFFFF, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_READ, 6'd2, 22'h3FFFFF, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_MODE, 6'd2, 22'h3FFFFF, gpoc_pkg::MODE_INTR, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_MODE, 6'd2, 22'h3FFFFF, gpoc_pkg::MODE_INVALID, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_FREE, 6'd2, 22'd1, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_FREE, 6'd2, 22'h3FFFFF, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
   endtask

   task automatic test_pin_faults();
      send_cmd(gpoc_pkg::CMD_REQUEST, 6'd0, 22'd1, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_READ, 6'd0, 22'd1, gpoc_pkg::MODE_IN, 1'b0, 1'b1);
      send_cmd(gpoc_pkg::CMD_READ, 6'd63, 22'd1, gpoc_pkg::MODE_IN, 1'b0, 1'b1);
      send_cmd(gpoc_pkg::CMD_WRITE, 6'd32, 22'd1, gpoc_pkg::MODE_IN, 1'b1, 1'b0);
      send_cmd(gpoc_pkg::CMD_TOGGLE, 6'd63, 22'h3FFFFF, gpoc_pkg::MODE_INVALID, 1'b1, 1'b1);
      send_cmd(gpoc_pkg::CMD_REQUEST, 6'd31, 22'd0, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_FREE, 6'd31, 22'd0, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
   endtask

   task automatic test_open_close();
      send_cmd(gpoc_pkg::CMD_CLOSE, 6'd0, 22'd1, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_REQUEST, 6'd31, 22'd7, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_OPEN, 6'd0, 22'd1, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_OPEN, 6'd0, 22'd1, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_CLOSE, 6'd0, 22'd1, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_REQUEST, 6'd31, 22'd8, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_CLOSE, 6'd0, 22'd1, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_REQUEST, 6'd31, 22'd8, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
   endtask

   // an owned pin reserved later survives the last close
   task automatic test_reserved_after_claim();
      load_reserved_mask(32'h0000_0000);
      send_cmd(gpoc_pkg::CMD_REQUEST, 6'd0, 22'd5, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_REQUEST, 6'd1, 22'd9, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_OPEN, 6'd0, 22'd5, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      load_reserved_mask(32'h0000_0001);
      send_cmd(gpoc_pkg::CMD_CLOSE, 6'd0, 22'd5, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      load_reserved_mask(32'h0000_0000);
      send_cmd(gpoc_pkg::CMD_REQUEST, 6'd0, 22'd6, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_REQUEST, 6'd1, 22'd6, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      send_cmd(gpoc_pkg::CMD_FREE, 6'd0, 22'd5, gpoc_pkg::MODE_IN, 1'b0, 1'b0);
      load_reserved_mask(gpoc_pkg::RESERVED_RESET);
   endtask

   // mostly claim / configure / drive / release sequences, plus raw noise
   task automatic test_random(input int n_items);
      int          sent;
      int          steps;
      logic [5:0]  p;
      logic [21:0] id;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(3))
            0:       id = 22'h3FFFFF;
            1:       id = 22'd1;
            2:       id = 22'($urandom_range(32'h3FFFFF, 1));
            default: id = ($urandom_range(9) == 0) ? 22'd0 : 22'd2;
         endcase
         p = 6'($urandom_range(31));
         for (int k = 0; k < 8 && mdl_mask[p[4:0]]; k++) p = 6'($urandom_range(31));
         if ($urandom_range(99) < 70) begin
            send_cmd(gpoc_pkg::CMD_REQUEST, p, id, gpoc_pkg::mode_type'($urandom_range(3)),
                     1'($urandom), 1'($urandom));
            send_cmd(gpoc_pkg::CMD_MODE, p, id, gpoc_pkg::mode_type'($urandom_range(3)),
                     1'($urandom), 1'($urandom));
            steps = $urandom_range(4, 1);
            repeat (steps)
               send_cmd(gpoc_pkg::cmd_type'($urandom_range(5, 3)), p, id,
                        gpoc_pkg::mode_type'($urandom_range(3)), 1'($urandom), 1'($urandom));
            sent += 2 + steps;
            if ($urandom_range(1)) begin
               send_cmd(gpoc_pkg::CMD_FREE, p, id, gpoc_pkg::mode_type'($urandom_range(3)),
                        1'($urandom), 1'($urandom));
               sent++;
            end
         end else begin
            send_cmd(gpoc_pkg::cmd_type'($urandom_range(7)), 6'($urandom_range(63)),
                     22'($urandom), gpoc_pkg::mode_type'($urandom_range(3)),
                     1'($urandom), 1'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      mdl_mask   = gpoc_pkg::RESERVED_RESET;
      mdl_dir    = '1;
      mdl_lvl    = '0;
      mdl_irq    = '0;
      user_count = '0;
      for (int i = 0; i < 32; i++) pin_owner[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(19, 65);
      test_pin_ownership();
      test_pin_faults();
      test_open_close();
      test_reserved_after_claim();

      wait_idle();
      load_reserved_mask(32'h0000_0000);
      test_random(170);

      wait_idle();
      set_idling(65, 19);
      load_reserved_mask($urandom);
      test_random(170);

      wait_idle();
      set_idling(0, 0);
      load_reserved_mask(gpoc_pkg::RESERVED_RESET);
      test_random(135);
      load_reserved_mask(32'hFFFF_FFFF);
      test_random(40);

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_gpio_pin_ownership_controller OK");
      end else begin
         $display("tb_gpio_pin_ownership_controller NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
src/gpoc_pkg.sv
src/gpoc_ram.sv
src/gpoc_exec.sv
src/gpio_pin_ownership_controller.sv
src/gpoc_checker.sv
tb/tb_gpio_pin_ownership_controller.sv
